### hdl/tcvc_pkg.sv
// shared types and constants for the triangle cull and vertex compaction unit
package tcvc_pkg;

   localparam int CornerW  = 16;
   localparam int QDepth   = 2;
   localparam int ReqDataW = 56;
   localparam int RspDataW = 40;

   // what the back end does with a queued triangle
   typedef enum logic [1:0] {
      KIND_PASS,
      KIND_REMAP,
      KIND_DROP
   } kind_type;

   typedef struct packed {
      logic [CornerW-1:0] corner_a;
      logic [CornerW-1:0] corner_b;
      logic [CornerW-1:0] corner_c;
      kind_type           kind;
      logic               new_mesh;
   } tri_type;

endpackage

### hdl/tcvc_ram.sv
// generic single write port, single read port ram with registered read
module tcvc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/tcvc_front.sv
// front end: takes triangles, classifies them and queues them for the back end
module tcvc_front #(
   parameter int MAX_VERTICES = 65536
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [tcvc_pkg::ReqDataW-1:0] req_tdata,
   input  logic                          req_tuser,
   input  logic                          enable_removal,
   input  logic                          accept_en,
   output logic                          q_valid,
   output tcvc_pkg::tri_type             q_entry,
   input  logic                          q_pop
);

   localparam logic [tcvc_pkg::CornerW:0] MaxIdx = (tcvc_pkg::CornerW + 1)'(MAX_VERTICES);
   localparam int PtrW  = $clog2(tcvc_pkg::QDepth);
   localparam int FillW = $clog2(tcvc_pkg::QDepth + 1);

   tcvc_pkg::tri_type entry_ff [tcvc_pkg::QDepth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FillW-1:0]  fill_ff, fill_in;

   tcvc_pkg::tri_type tri_new;
   logic              beyond;
   logic              cull;
   logic              accept;
   logic              push;
   logic              full;

   always_comb begin
      tri_new.corner_a = req_tdata[15:0];
      tri_new.corner_b = req_tdata[31:16];
      tri_new.corner_c = req_tdata[47:32];
      tri_new.new_mesh = req_tuser;
      beyond = ({1'b0, tri_new.corner_a} >= MaxIdx) ||
               ({1'b0, tri_new.corner_b} >= MaxIdx) ||
               ({1'b0, tri_new.corner_c} >= MaxIdx);
      cull = req_tdata[48] || req_tdata[49] || req_tdata[50] || req_tdata[51] || beyond;
      if (!enable_removal) begin
         tri_new.kind = tcvc_pkg::KIND_PASS;
      end else if (cull) begin
         tri_new.kind = tcvc_pkg::KIND_DROP;
      end else begin
         tri_new.kind = tcvc_pkg::KIND_REMAP;
      end
   end

   assign full       = (fill_ff == FillW'(tcvc_pkg::QDepth));
   assign req_tready = accept_en && !full;
   assign accept     = req_tvalid && req_tready;
   // a culled triangle only travels on when it still has to reset the counter
   assign push       = accept && !(tri_new.kind == tcvc_pkg::KIND_DROP && !tri_new.new_mesh);

   assign q_valid = (fill_ff != '0);
   assign q_entry = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(tcvc_pkg::QDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(tcvc_pkg::QDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (q_pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= tri_new;
      end
   end

endmodule

### hdl/tcvc_back.sv
// back end: clears the tables after reset, remaps or passes through corners and drives the result register
module tcvc_back #(
   parameter int MAX_VERTICES = 65536
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  tcvc_pkg::tri_type             q_entry,
   output logic                          q_pop,
   output logic                          clearing,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [tcvc_pkg::RspDataW-1:0] rsp_tdata,
   output logic                          rsp_tlast
);

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam logic [1:0] LastCorner = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_CHECK,
      ST_VERIFY,
      ST_PASS
   } state_type;

   state_type                    state_ff, state_in;
   tcvc_pkg::tri_type            tri_ff, tri_in;
   logic [1:0]                   sel_ff, sel_in;
   logic [CW-1:0]                count_ff, count_in;
   logic [AW-1:0]                clr_ff, clr_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [tcvc_pkg::CornerW-1:0] rsp_mapped_ff, rsp_mapped_in;
   logic [tcvc_pkg::CornerW-1:0] rsp_source_ff, rsp_source_in;
   logic                         rsp_new_ff, rsp_new_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic [tcvc_pkg::CornerW-1:0] corner_cur;
   logic [AW-1:0]                old_idx;
   logic                         out_free;
   logic                         hit;

   logic          map_we, map_re;
   logic [AW-1:0] map_waddr, map_wdata, map_q;
   logic          rev_we, rev_re;
   logic [AW-1:0] rev_waddr, rev_wdata, rev_q;

   // forward table: old index to new index
   tcvc_ram #(.WIDTH(AW), .DEPTH(MAX_VERTICES)) u_map_ram (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_waddr),
      .wr_data (map_wdata),
      .rd_en   (map_re),
      .rd_addr (old_idx),
      .rd_data (map_q)
   );

   // reverse table: new index back to old index, confirms a forward entry
   tcvc_ram #(.WIDTH(AW), .DEPTH(MAX_VERTICES)) u_rev_ram (
      .clock   (clock),
      .wr_en   (rev_we),
      .wr_addr (rev_waddr),
      .wr_data (rev_wdata),
      .rd_en   (rev_re),
      .rd_addr (map_q),
      .rd_data (rev_q)
   );

   always_comb begin
      unique case (sel_ff)
         2'd0:    corner_cur = tri_ff.corner_a;
         2'd1:    corner_cur = tri_ff.corner_b;
         default: corner_cur = tri_ff.corner_c;
      endcase
   end

   assign old_idx  = corner_cur[AW-1:0];
   assign out_free = !rsp_valid_ff || rsp_tready;
   // mapping is live only if it lies below the counter and points back here
   assign hit      = (CW'(map_q) < count_ff) && (rev_q == old_idx);

   always_comb begin
      state_in      = state_ff;
      tri_in        = tri_ff;
      sel_in        = sel_ff;
      count_in      = count_ff;
      clr_in        = clr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_mapped_in = rsp_mapped_ff;
      rsp_source_in = rsp_source_ff;
      rsp_new_in    = rsp_new_ff;
      rsp_last_in   = rsp_last_ff;
      q_pop         = 1'b0;
      map_we        = 1'b0;
      map_re        = 1'b0;
      map_waddr     = old_idx;
      map_wdata     = count_ff[AW-1:0];
      rev_we        = 1'b0;
      rev_re        = 1'b0;
      rev_waddr     = count_ff[AW-1:0];
      rev_wdata     = old_idx;

      unique case (state_ff)
         ST_CLEAR: begin
            map_we    = 1'b1;
            rev_we    = 1'b1;
            map_waddr = clr_ff;
            map_wdata = '0;
            rev_waddr = clr_ff;
            rev_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == AW'(MAX_VERTICES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               tri_in = q_entry;
               sel_in = '0;
               if (q_entry.new_mesh) begin
                  count_in = '0;
               end
               unique case (q_entry.kind)
                  tcvc_pkg::KIND_PASS:  state_in = ST_PASS;
                  tcvc_pkg::KIND_REMAP: state_in = ST_LOOKUP;
                  default:              state_in = ST_IDLE;
               endcase
            end
         end
         ST_LOOKUP: begin
            map_re   = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            rev_re   = 1'b1;
            state_in = ST_VERIFY;
         end
         ST_VERIFY: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_source_in = corner_cur;
               rsp_new_in    = !hit;
               rsp_last_in   = (sel_ff == LastCorner);
               if (hit) begin
                  rsp_mapped_in = tcvc_pkg::CornerW'(map_q);
               end else begin
                  rsp_mapped_in = tcvc_pkg::CornerW'(count_ff);
                  map_we        = 1'b1;
                  rev_we        = 1'b1;
                  count_in      = count_ff + 1'b1;
               end
               if (sel_ff == LastCorner) begin
                  state_in = ST_IDLE;
               end else begin
                  sel_in   = sel_ff + 1'b1;
                  state_in = ST_LOOKUP;
               end
            end
         end
         ST_PASS: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_source_in = corner_cur;
               rsp_mapped_in = corner_cur;
               rsp_new_in    = 1'b0;
               rsp_last_in   = (sel_ff == LastCorner);
               if (sel_ff == LastCorner) begin
                  state_in = ST_IDLE;
               end else begin
                  sel_in = sel_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sel_ff       <= '0;
         count_ff     <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         count_ff     <= count_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tri_ff        <= tri_in;
      rsp_mapped_ff <= rsp_mapped_in;
      rsp_source_ff <= rsp_source_in;
      rsp_new_ff    <= rsp_new_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign clearing   = (state_ff == ST_CLEAR);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_new_ff, rsp_source_ff, rsp_mapped_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

### hdl/triangle_cull_vertex_compaction_unit.sv
// top level of the triangle cull and vertex compaction unit
//
// channel  direction  payload
// req      in         tdata: corner_a, corner_b, corner_c, is_wet, below_a, below_b, below_c
//                     tuser: new_mesh
// rsp      out        tdata: mapped_index, source_index, is_new; tlast: last
// csr      in         csr_wdata: enable_removal
//
// a remapped triangle is taken from the queue in ST_IDLE, then each corner steps through
// ST_LOOKUP (forward table read), ST_CHECK (reverse table read) and ST_VERIFY (check and write)
// a pass-through triangle visits ST_PASS once per corner; a culled one is popped in ST_IDLE or never queued
// after reset both tables are swept to zero, with req_tready low during the sweep
// a two-entry queue keeps accepting triangles, until it is full, while rsp_tready holds the back end
module triangle_cull_vertex_compaction_unit #(
   parameter int MAX_VERTICES = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,  // corner_a, corner_b, corner_c, is_wet, below_a..c, zeros
   input  logic        req_tuser,  // new_mesh
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // mapped_index, source_index, is_new, zeros
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic        csr_wdata
);

   logic              enable_removal_ff;
   logic              q_valid;
   logic              q_pop;
   logic              clearing;
   tcvc_pkg::tri_type q_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_removal_ff <= 1'b1;
      end else if (csr_we) begin
         enable_removal_ff <= csr_wdata;
      end
   end

   tcvc_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .enable_removal (enable_removal_ff),
      .accept_en      (!clearing),
      .q_valid        (q_valid),
      .q_entry        (q_entry),
      .q_pop          (q_pop)
   );

   tcvc_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .q_pop      (q_pop),
      .clearing   (clearing),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTH
   // no transfer is taken while the tables are being swept
   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req_tready)
      else $error("req accepted during table sweep");

   // pass-through never asks for a vertex copy
   a_pass_not_new: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !enable_removal_ff) |-> !rsp_tdata[32])
      else $error("is_new set with removal disabled");

   // pass-through keeps the old index
   a_pass_same_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !enable_removal_ff) |-> (rsp_tdata[15:0] == rsp_tdata[31:16]))
      else $error("pass-through index changed");

   // the queue never hands out an entry when it is empty
   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");
`endif

endmodule
